// ----- hdl/assert_macros.svh -----
// Assertion macros used by the recoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cond on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check that cause implies effect in the same cycle
`define ASSERT_SAME(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error(msg);

// check that cause implies effect in the following cycle
`define ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`endif

// ----- hdl/msjsf_pkg.sv -----
// Types, constants and helpers of the joint sparse form recoder
`timescale 1ns / 1ps

package msjsf_pkg;

   localparam int MAX_D  = 8;
   localparam int LANE_W = 8;
   localparam int DIM_W  = 4;

   typedef logic [LANE_W-1:0] lanes_type;
   typedef logic [DIM_W-1:0]  dim_type;

   localparam dim_type DIM_RESET = DIM_W'(2);

   typedef enum logic [1:0] {
      PH_MAIN,
      PH_FLUSH,
      PH_EXTRA
   } phase_type;

   typedef struct packed {
      lanes_type odd;
      lanes_type neg;
      lanes_type carry;
      lanes_type held;
      lanes_type run;
   } col_result_type;

   function automatic lanes_type lane_mask(input dim_type dim);
      logic [LANE_W:0] full;
      begin
         full = ({{LANE_W{1'b0}}, 1'b1} << dim) - {{LANE_W{1'b0}}, 1'b1};
         if (dim >= DIM_W'(MAX_D)) begin
            lane_mask = '1;
         end else begin
            lane_mask = full[LANE_W-1:0];
         end
      end
   endfunction

endpackage

// ----- hdl/multi_scalar_jsf_recoder.sv -----
// Top level: d-dimensional joint sparse form recoder over bit columns
// A column word waits in the input word register; the digit column it releases is registered
//   in the result word register, then the one or two flush columns of a last word follow it.
// Throughput: one column word or flush column per cycle while the result register is free.
// Reset: synchronous, clears the run state, the flush phase and both valid flags;
//   dimension_count returns to 2.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_scalar_jsf_recoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] column_bits
   input  logic        req_tlast,   // last_column
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] digit_nonzero, [15:8] digit_negative
   output logic        rsp_tlast,   // final_digit
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data     // dimension_count
);
   import msjsf_pkg::*;

   dim_type        dim_ff;
   logic           in_valid_ff;
   lanes_type      in_col_ff;
   logic           in_last_ff;
   phase_type      phase_ff, phase_in;
   lanes_type      held_ff, held_in;
   lanes_type      carry_ff, carry_in;
   lanes_type      run_ff, run_in;
   logic           started_ff, started_in;
   logic           rsp_valid_ff;
   lanes_type      rsp_odd_ff, rsp_neg_ff;
   logic           rsp_final_ff;

   lanes_type      mask;
   lanes_type      next_col;
   col_result_type col;
   logic           out_free;
   logic           emit;
   logic           retire;
   logic           final_step;

   assign mask     = lane_mask(dim_ff);
   assign next_col = (phase_ff == PH_MAIN) ? (in_col_ff & mask) : '0;
   assign out_free = !rsp_valid_ff || rsp_tready;

   msjsf_column u_column (
      .held   (held_ff),
      .carry  (carry_ff),
      .run    (run_ff),
      .next   (next_col),
      .mask   (mask),
      .result (col)
   );

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         dim_ff <= csr_data;
      end
   end

   // input word register
   assign req_tready = !in_valid_ff || retire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_col_ff  <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // run state and flush phase
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAIN;
         held_ff    <= '0;
         carry_ff   <= '0;
         run_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         carry_ff   <= carry_in;
         run_ff     <= run_in;
         started_ff <= started_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      carry_in   = carry_ff;
      run_in     = run_ff;
      started_in = started_ff;
      emit       = 1'b0;
      retire     = 1'b0;
      final_step = 1'b0;
      if (in_valid_ff) begin
         unique case (phase_ff)
            PH_MAIN: begin
               if (!started_ff) begin
                  held_in    = next_col;
                  carry_in   = '0;
                  run_in     = next_col;
                  started_in = 1'b1;
                  if (in_last_ff) begin
                     phase_in = PH_FLUSH;
                  end else begin
                     retire = 1'b1;
                  end
               end else if (out_free) begin
                  emit     = 1'b1;
                  held_in  = col.held;
                  carry_in = col.carry;
                  run_in   = col.run;
                  if (in_last_ff) begin
                     phase_in = PH_FLUSH;
                  end else begin
                     retire = 1'b1;
                  end
               end
            end
            PH_FLUSH: begin
               if (out_free) begin
                  emit     = 1'b1;
                  held_in  = col.held;
                  carry_in = col.carry;
                  run_in   = col.run;
                  if (col.carry == '0) begin
                     final_step = 1'b1;
                  end else begin
                     phase_in = PH_EXTRA;
                  end
               end
            end
            PH_EXTRA: begin
               if (out_free) begin
                  emit       = 1'b1;
                  final_step = 1'b1;
               end
            end
            default: begin
               phase_in = PH_MAIN;
            end
         endcase
         if (final_step) begin
            retire     = 1'b1;
            phase_in   = PH_MAIN;
            held_in    = '0;
            carry_in   = '0;
            run_in     = '0;
            started_in = 1'b0;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_odd_ff   <= col.odd;
         rsp_neg_ff   <= col.neg;
         rsp_final_ff <= final_step;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_neg_ff, rsp_odd_ff};
   assign rsp_tlast  = rsp_final_ff;

   `ASSERT_SAME(a_neg_in_nonzero, clock, reset, rsp_tvalid,
      (rsp_tdata[15:8] & ~rsp_tdata[7:0]) == 8'd0, "negative digit marked zero")
   `ASSERT_NEXT(a_final_clears_run, clock, reset, final_step,
      !started_ff && carry_ff == '0 && phase_ff == PH_MAIN, "run state kept after final digit")
   `ASSERT_SAME(a_flush_holds_word, clock, reset, phase_ff != PH_MAIN,
      in_valid_ff && in_last_ff, "flush phase without a last column word")
   `ASSERT_ALWAYS(a_emit_has_room, clock, reset, !emit || out_free,
      "result word overwritten")

endmodule

// ----- hdl/msjsf_column.sv -----
// One digit column of the joint recoding with its carry and parity update
`timescale 1ns / 1ps

module msjsf_column (
   input  msjsf_pkg::lanes_type      held,
   input  msjsf_pkg::lanes_type      carry,
   input  msjsf_pkg::lanes_type      run,
   input  msjsf_pkg::lanes_type      next,
   input  msjsf_pkg::lanes_type      mask,
   output msjsf_pkg::col_result_type result
);
   import msjsf_pkg::*;

   lanes_type h;
   lanes_type c;
   lanes_type odd;
   lanes_type next_odd;
   lanes_type neg;
   lanes_type carry_out;
   lanes_type held_out;

   assign h         = held & mask;
   assign c         = carry & mask;
   assign odd       = run & mask;
   assign next_odd  = (next & mask) ^ (h & c);
   assign neg       = ((next_odd | odd) == odd) ? next_odd : (odd & ~next_odd & mask);
   assign carry_out = ((h & c) | neg) & mask;
   assign held_out  = next & mask;

   assign result.odd   = odd;
   assign result.neg   = neg;
   assign result.carry = carry_out;
   assign result.held  = held_out;
   assign result.run   = held_out ^ carry_out;

endmodule
